>>> hdl/best_rational_approximation_core_assert.svh
// Assertion macros shared by the approximation core.
// The macros expect signals named clk and rst_n in the calling scope.
`ifndef BEST_RATIONAL_APPROXIMATION_CORE_ASSERT_SVH
`define BEST_RATIONAL_APPROXIMATION_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked property, disabled while reset is active
`define BRA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked property, also evaluated during reset
`define BRA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BRA_ASSERT(lbl, prop, msg)
`define BRA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> hdl/bra_pkg.sv
package bra_pkg;

    // Field width of all operands and results
    localparam int DW = 32;
    // Significant operand bits; higher bits of inputs and writes are ignored
    localparam int OPW = 32;
    localparam logic [63:0] OPW_MASK64 = (64'd1 << OPW) - 64'd1;
    localparam logic [DW-1:0] OPW_MASK = OPW_MASK64[DW-1:0];

    // Divider runs one quotient bit per cycle
    localparam int DIV_STEPS = DW;
    localparam int CNT_W = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    // Register reset values
    localparam logic [DW-1:0] NUM_LIMIT_RESET = 32'h00FF_FFFF;
    localparam logic [DW-1:0] DEN_LIMIT_RESET = 32'd256;

    // Register indexes
    localparam logic REG_NUM_LIMIT = 1'b0;
    localparam logic REG_DEN_LIMIT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_DIV,
        ST_MUL_P,
        ST_MUL_Q,
        ST_CHECK,
        ST_FINISH
    } bra_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;      // take a new ratio, reset convergents
        logic div_init;  // start a division top / bot
        logic div_step;  // one restoring division step
        logic mul_p;     // product quot * p_cur
        logic mul_q;     // p_next sum, product quot * q_cur
        logic advance;   // commit convergent, shift Euclid pair
        logic finish;    // latch result
    } bra_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic bot_zero;  // ratio exhausted
        logic fits;      // candidate convergent within both limits
    } bra_stat_t;

endpackage

>>> hdl/bra_ctrl.sv
module bra_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  bra_pkg::bra_stat_t stat,
    output bra_pkg::bra_cmd_t  cmd,
    output logic              busy,
    output logic              done
);
    import bra_pkg::*;

    bra_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;

    // State, step counter and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_TEST;
            end
            ST_TEST:
            begin
                if (stat.bot_zero)
                    state_next = ST_FINISH;
                else
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_LAST)
                    state_next = ST_MUL_P;
            end
            ST_MUL_P:  state_next = ST_MUL_Q;
            ST_MUL_Q:  state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (stat.fits)
                    state_next = ST_TEST;
                else
                    state_next = ST_FINISH;
            end
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs and counter
    always_comb
    begin
        cmd       = '0;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        busy      = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = start;
            end
            ST_TEST:
            begin
                cmd.div_init = !stat.bot_zero;
                cnt_next     = '0;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + CNT_W'(1);
            end
            ST_MUL_P:  cmd.mul_p = 1'b1;
            ST_MUL_Q:  cmd.mul_q = 1'b1;
            ST_CHECK:  cmd.advance = stat.fits;
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                done_next  = 1'b1;
            end
            default:   cmd = '0;
        endcase
    end

    assign done = done_reg;

endmodule

>>> hdl/bra_datapath.sv
module bra_datapath (
    input  logic                    clk,
    input  bra_pkg::bra_cmd_t       cmd,
    input  logic [bra_pkg::DW-1:0]  ratio_top,
    input  logic [bra_pkg::DW-1:0]  ratio_bottom,
    input  logic [bra_pkg::DW-1:0]  lim_n,
    input  logic [bra_pkg::DW-1:0]  lim_d,
    output bra_pkg::bra_stat_t      stat,
    output logic [bra_pkg::DW-1:0]  approx_top,
    output logic [bra_pkg::DW-1:0]  approx_bottom
);
    import bra_pkg::*;

    // Euclid pair and convergents
    logic [DW-1:0]   top_reg, bot_reg;
    logic [DW-1:0]   p_prev_reg, q_prev_reg, p_cur_reg, q_cur_reg;
    // Divider: partial remainder and quotient/dividend shift register
    logic [DW-1:0]   rem_reg, quo_reg;
    // Shared multiplier output and p candidate
    logic [2*DW-1:0] prod_reg, pn_reg;
    logic [DW-1:0]   out_top_reg, out_bot_reg;

    logic [DW:0]     shifted, diff;
    logic            ge;
    logic [DW-1:0]   mul_b;
    logic [2*DW-1:0] prod_comb, qn;
    logic            p_ok, q_ok;

    // Restoring division step
    assign shifted = {rem_reg, quo_reg[DW-1]};
    assign diff    = shifted - {1'b0, bot_reg};
    assign ge      = (shifted >= {1'b0, bot_reg});

    // One multiplier, shared between the p and q products
    assign mul_b     = cmd.mul_q ? q_cur_reg : p_cur_reg;
    assign prod_comb = (2*DW)'(quo_reg) * (2*DW)'(mul_b);

    // Limit check of the candidate convergent
    assign qn   = {{DW{1'b0}}, q_prev_reg} + prod_reg;
    assign p_ok = (pn_reg[2*DW-1:DW] == '0) && (pn_reg[DW-1:0] <= lim_n);
    assign q_ok = (qn[2*DW-1:DW] == '0) && (qn[DW-1:0] <= lim_d);

    assign stat.fits     = p_ok && q_ok;
    assign stat.bot_zero = (bot_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            top_reg    <= ratio_top & OPW_MASK;
            bot_reg    <= ratio_bottom & OPW_MASK;
            p_prev_reg <= '0;
            q_prev_reg <= DW'(1);
            p_cur_reg  <= DW'(1);
            q_cur_reg  <= '0;
        end

        if (cmd.div_init)
        begin
            rem_reg <= '0;
            quo_reg <= top_reg;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? diff[DW-1:0] : shifted[DW-1:0];
            quo_reg <= {quo_reg[DW-2:0], ge};
        end

        if (cmd.mul_p || cmd.mul_q)
            prod_reg <= prod_comb;
        if (cmd.mul_q)
            pn_reg <= {{DW{1'b0}}, p_prev_reg} + prod_reg;

        // Commit convergent and move to the next remainder
        if (cmd.advance)
        begin
            p_prev_reg <= p_cur_reg;
            q_prev_reg <= q_cur_reg;
            p_cur_reg  <= pn_reg[DW-1:0];
            q_cur_reg  <= qn[DW-1:0];
            top_reg    <= bot_reg;
            bot_reg    <= rem_reg;
        end

        // Latch the result: the last fitting convergent, or limit over one if none fitted
        if (cmd.finish)
        begin
            if (q_cur_reg == '0)
            begin
                out_top_reg <= lim_n;
                out_bot_reg <= DW'(1);
            end
            else
            begin
                out_top_reg <= p_cur_reg;
                out_bot_reg <= q_cur_reg;
            end
        end
    end

    assign approx_top    = out_top_reg;
    assign approx_bottom = out_bot_reg;

endmodule

>>> hdl/best_rational_approximation_core.sv
// Best rational approximation core.
// Input: drive ratio_top / ratio_bottom and pulse start; the ratio is
// transferred at a clock edge where start is high and busy is low. busy
// stays high until the result has been formed.
// Output: done is high for exactly one cycle with approx_top/approx_bottom,
// the best continued-fraction convergent within numerator_limit and
// denominator_limit (limit over 1 if none fits or the denominator is zero).
// The receiver cannot stall; the result ports hold until the next result.
// Each Euclid step runs a test, the bit-serial divider, two passes
// through the shared multiplier and one limit check; when the last step
// breaks a limit, its check goes straight to the result.
// Worst case about 46 Euclid steps; a zero denominator goes from the
// test straight to the result. One ratio is worked on at a time.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 numerator
// limit, 1 denominator limit) at once; write only while busy is low.
// Reset: asynchronous, active low; limits return to 0xFFFFFF and 256,
// the controller to idle, done low.
module best_rational_approximation_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [bra_pkg::DW-1:0] ratio_top,
    input  logic [bra_pkg::DW-1:0] ratio_bottom,
    output logic                   done,
    output logic [bra_pkg::DW-1:0] approx_top,
    output logic [bra_pkg::DW-1:0] approx_bottom,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [bra_pkg::DW-1:0] cfg_data
);
    import bra_pkg::*;
    `include "best_rational_approximation_core_assert.svh"

    logic [DW-1:0] num_limit_reg, den_limit_reg;
    bra_cmd_t      cmd;
    bra_stat_t     stat;

    // Limit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_limit_reg <= NUM_LIMIT_RESET;
            den_limit_reg <= DEN_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NUM_LIMIT: num_limit_reg <= cfg_data & OPW_MASK;
                REG_DEN_LIMIT: den_limit_reg <= cfg_data & OPW_MASK;
                default:       num_limit_reg <= num_limit_reg;
            endcase
        end
    end

    bra_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    bra_datapath u_datapath (
        .clk           (clk),
        .cmd           (cmd),
        .ratio_top     (ratio_top),
        .ratio_bottom  (ratio_bottom),
        .lim_n         (num_limit_reg),
        .lim_d         (den_limit_reg),
        .stat          (stat),
        .approx_top    (approx_top),
        .approx_bottom (approx_bottom)
    );

    `BRA_ASSERT(a_start_busy, (start && !busy) |=> busy, "transfer did not raise busy")
    `BRA_ASSERT(a_done_pulse, done |=> !done, "done longer than one cycle")
    `BRA_ASSERT(a_den_nonzero, done |-> (approx_bottom != '0), "zero result denominator")
    `BRA_ASSERT(a_done_after_busy, done |-> $past(busy), "done without work in progress")

endmodule

>>> verif/best_rational_approximation_core_tb.sv
module best_rational_approximation_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bra_pkg::*;

    localparam int CLK_PERIOD = 10;
    localparam int RESET_CYCLES = 5;
    // Bound on the whole run, set well above the slowest legal run
    localparam longint TIMEOUT_NS = 64'd40_000_000;
    localparam int SEGMENTS_PER_PHASE = 3;
    localparam int ITEMS_PER_SEGMENT = 45;
    localparam int DRAIN_GUARD = 5000;
    localparam int TAIL_CYCLES = 50;
    localparam logic [DW-1:0] ALL_ONES = {DW{1'b1}};

    typedef struct packed {
        logic [DW-1:0] top;
        logic [DW-1:0] bottom;
    } approx_t;

    // One directed transfer: limits in force, ratio, optional hand-typed answer
    typedef struct packed {
        logic [DW-1:0] lim_n;
        logic [DW-1:0] lim_d;
        logic [DW-1:0] top;
        logic [DW-1:0] bot;
        logic          typed;
        logic [DW-1:0] exp_top;
        logic [DW-1:0] exp_bot;
    } directed_row_t;

    localparam int NUM_DIRECTED = 24;
    localparam directed_row_t DIRECTED_ROWS [0:NUM_DIRECTED-1] = '{
        // reset limits
        '{32'h00FF_FFFF, 32'd256, 32'd0, 32'd0, 1'b1, 32'h00FF_FFFF, 32'd1},
        '{32'h00FF_FFFF, 32'd256, 32'd0, 32'd5, 1'b1, 32'd0, 32'd1},
        '{32'h00FF_FFFF, 32'd256, 32'd7, 32'd1, 1'b1, 32'd7, 32'd1},
        '{32'h00FF_FFFF, 32'd256, 32'd355, 32'd113, 1'b0, 32'd0, 32'd0},
        '{32'h00FF_FFFF, 32'd256, 32'hFFFF_FFFF, 32'd1, 1'b1, 32'h00FF_FFFF, 32'd1},
        '{32'h00FF_FFFF, 32'd256, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd1, 32'd1},
        '{32'h00FF_FFFF, 32'd256, 32'd1, 32'hFFFF_FFFF, 1'b1, 32'd0, 32'd1},
        '{32'h00FF_FFFF, 32'd256, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'd0, 32'd0},
        '{32'h00FF_FFFF, 32'd256, 32'd2971215073, 32'd1836311903, 1'b0, 32'd0, 32'd0},
        // widest limits
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd2971215073, 32'd1836311903, 1'b0, 32'd0, 32'd0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 1'b1, 32'hFFFF_FFFF, 32'd1},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0, 1'b1, 32'hFFFF_FFFF, 32'd1},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, 32'd0, 32'd0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 1'b0, 32'd0, 32'd0},
        // tightest legal limits
        '{32'd1, 32'd1, 32'd1, 32'd1, 1'b1, 32'd1, 32'd1},
        '{32'd1, 32'd1, 32'd2, 32'd1, 1'b1, 32'd1, 32'd1},
        '{32'd1, 32'd1, 32'd1, 32'd2, 1'b1, 32'd0, 32'd1},
        '{32'd1, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd1, 32'd1},
        // zero limits: nothing fits
        '{32'd0, 32'd0, 32'd0, 32'd7, 1'b1, 32'd0, 32'd1},
        '{32'd0, 32'd0, 32'd5, 32'd0, 1'b1, 32'd0, 32'd1},
        // zero numerator limit admits only 0/1
        '{32'd0, 32'hFFFF_FFFF, 32'd0, 32'd9, 1'b1, 32'd0, 32'd1},
        '{32'd0, 32'hFFFF_FFFF, 32'd3, 32'd4, 1'b1, 32'd0, 32'd1},
        '{32'd0, 32'hFFFF_FFFF, 32'd9, 32'd4, 1'b1, 32'd0, 32'd1},
        // zero denominator limit falls back to limit over 1
        '{32'd1000, 32'd0, 32'd22, 32'd7, 1'b1, 32'd1000, 32'd1}
    };

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    logic [DW-1:0] ratio_top = '0;
    logic [DW-1:0] ratio_bottom = '0;
    logic          done;
    logic [DW-1:0] approx_top;
    logic [DW-1:0] approx_bottom;
    logic          cfg_we = 1'b0;
    logic          cfg_index = REG_NUM_LIMIT;
    logic [DW-1:0] cfg_data = '0;

    // Shadow of the limit registers
    logic [DW-1:0] num_limit = NUM_LIMIT_RESET;
    logic [DW-1:0] den_limit = DEN_LIMIT_RESET;

    approx_t pending_approx [$];
    int      send_idle_pct = 0;
    int      failures = 0;
    int      ratios_sent = 0;
    int      results_checked = 0;
    int      limit_writes = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    best_rational_approximation_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .ratio_top    (ratio_top),
        .ratio_bottom (ratio_bottom),
        .done         (done),
        .approx_top   (approx_top),
        .approx_bottom(approx_bottom),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Last continued-fraction convergent within both limits, else limit over one
    function automatic approx_t best_convergent(
        input logic [DW-1:0] top_in,
        input logic [DW-1:0] bot_in,
        input logic [DW-1:0] lim_n,
        input logic [DW-1:0] lim_d
    );
        logic [DW-1:0] top;
        logic [DW-1:0] bot;
        logic [DW-1:0] quot;
        logic [DW-1:0] rem;
        logic [DW-1:0] p_prev;
        logic [DW-1:0] q_prev;
        logic [DW-1:0] p_cur;
        logic [DW-1:0] q_cur;
        logic [63:0]   p_next;
        logic [63:0]   q_next;
        approx_t       res;
        top = top_in & OPW_MASK;
        bot = bot_in & OPW_MASK;
        p_prev = '0;
        q_prev = DW'(1);
        p_cur = DW'(1);
        q_cur = '0;
        while (bot != '0) begin
            quot = top / bot;
            rem = top % bot;
            p_next = 64'(p_prev) + 64'(quot) * 64'(p_cur);
            q_next = 64'(q_prev) + 64'(quot) * 64'(q_cur);
            if (p_next > 64'(lim_n) || q_next > 64'(lim_d))
                break;
            p_prev = p_cur;
            q_prev = q_cur;
            p_cur = p_next[DW-1:0];
            q_cur = q_next[DW-1:0];
            top = bot;
            bot = rem;
        end
        // nothing fitted, or zero denominator
        if (q_cur == '0) begin
            p_cur = lim_n;
            q_cur = DW'(1);
        end
        res.top = p_cur;
        res.bottom = q_cur;
        return res;
    endfunction

    // Drop start and wait until the core has delivered everything it owes
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_approx.size() != 0 || busy)
            @(posedge clk);
    endtask

    // Program both limits back to back; core must be idle
    task automatic write_limits(input logic [DW-1:0] lim_n, input logic [DW-1:0] lim_d);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_NUM_LIMIT;
        cfg_data <= lim_n;
        @(posedge clk);
        cfg_index <= REG_DEN_LIMIT;
        cfg_data <= lim_d;
        @(posedge clk);
        cfg_we <= 1'b0;
        num_limit = lim_n & OPW_MASK;
        den_limit = lim_d & OPW_MASK;
        limit_writes += 2;
    endtask

    // Offer one ratio; returns right after the edge that transfers it.
    // Start is left high so back-to-back items need no extra toggle.
    task automatic send_ratio(input logic [DW-1:0] top, input logic [DW-1:0] bot);
        while ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        ratio_top <= top;
        ratio_bottom <= bot;
        do
            @(posedge clk);
        while (busy);
        ratios_sent++;
    endtask

    // Result checker: done is a one-cycle strobe, sampled at the closing edge
    always @(posedge clk) begin : check_result
        approx_t want;
        if (rst_n && done) begin
            if (pending_approx.size() == 0) begin
                $error("unexpected result %0d/%0d", approx_top, approx_bottom);
                failures++;
            end else begin
                want = pending_approx.pop_front();
                results_checked++;
                if (approx_top !== want.top) begin
                    $error("approx_top mismatch: expected %0d, actual %0d",
                           want.top, approx_top);
                    failures++;
                end
                if (approx_bottom !== want.bottom) begin
                    $error("approx_bottom mismatch: expected %0d, actual %0d",
                           want.bottom, approx_bottom);
                    failures++;
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("best_rational_approximation_core_tb failed");
        $finish;
    end

    initial begin : stimulus
        directed_row_t row;
        approx_t       typed_approx;
        int            phase_idle [3];
        int            mode;
        int            guard;
        int            fib_steps;
        logic [DW-1:0] fib_lo;
        logic [DW-1:0] fib_hi;
        logic [DW-1:0] fib_next;
        logic [DW-1:0] lim_n;
        logic [DW-1:0] lim_d;
        logic [DW-1:0] top;
        logic [DW-1:0] bot;
        logic [DW-1:0] corner [4];

        phase_idle = '{14, 83, 0};
        corner = '{'0, DW'(1), ALL_ONES, {1'b1, {(DW-1){1'b0}}}};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; limits change only with the core idle
        send_idle_pct = phase_idle[0];
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            row = DIRECTED_ROWS[i];
            if (row.lim_n != num_limit || row.lim_d != den_limit) begin
                wait_idle();
                write_limits(row.lim_n, row.lim_d);
            end
            send_ratio(row.top, row.bot);
            if (row.typed) begin
                typed_approx.top = row.exp_top;
                typed_approx.bottom = row.exp_bot;
                pending_approx.push_back(typed_approx);
            end else begin
                pending_approx.push_back(best_convergent(row.top, row.bot,
                                                         num_limit, den_limit));
            end
        end

        // Random part: three idling phases, a fresh limit setting per segment
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = phase_idle[ph];
            for (int seg = 0; seg < SEGMENTS_PER_PHASE; seg++) begin
                mode = $urandom_range(5);
                case (mode)
                    0: begin lim_n = $urandom; lim_d = $urandom; end
                    1: begin lim_n = ALL_ONES; lim_d = ALL_ONES; end
                    2: begin lim_n = $urandom_range(1, 1000); lim_d = $urandom_range(1, 1000); end
                    3: begin lim_n = NUM_LIMIT_RESET; lim_d = DEN_LIMIT_RESET; end
                    4: begin lim_n = ALL_ONES; lim_d = $urandom_range(1, 300); end
                    default: begin lim_n = $urandom_range(1, 65535); lim_d = ALL_ONES; end
                endcase
                wait_idle();
                write_limits(lim_n, lim_d);

                for (int k = 0; k < ITEMS_PER_SEGMENT; k++) begin
                    mode = $urandom_range(99);
                    if (mode < 45) begin
                        top = $urandom;
                        bot = $urandom;
                    end else if (mode < 60) begin
                        // consecutive Fibonacci numbers give the longest chains
                        fib_steps = $urandom_range(0, 45);
                        fib_lo = DW'(1);
                        fib_hi = DW'(1);
                        repeat (fib_steps) begin
                            fib_next = fib_lo + fib_hi;
                            fib_lo = fib_hi;
                            fib_hi = fib_next;
                        end
                        if ($urandom_range(1)) begin
                            top = fib_hi;
                            bot = fib_lo;
                        end else begin
                            top = fib_lo;
                            bot = fib_hi;
                        end
                    end else if (mode < 75) begin
                        top = $urandom_range(255);
                        bot = $urandom_range(255);
                    end else if (mode < 85) begin
                        // near multiples: large quotient or remainder close to zero
                        bot = $urandom;
                        top = bot * $urandom_range(1, 3) + $urandom_range(2);
                    end else if (mode < 92) begin
                        top = $urandom;
                        bot = $urandom;
                        if ($urandom_range(1))
                            bot = '0;
                        else
                            top = '0;
                    end else begin
                        top = corner[$urandom_range(3)];
                        bot = corner[$urandom_range(3)];
                    end
                    send_ratio(top, bot);
                    pending_approx.push_back(best_convergent(top, bot, num_limit, den_limit));
                end
            end
        end

        // Drain, bounded so a lost result shows up as a leftover
        start <= 1'b0;
        guard = 0;
        while (pending_approx.size() != 0 && guard < DRAIN_GUARD) begin
            @(posedge clk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_approx.size() != 0) begin
            $error("%0d expected results never arrived", pending_approx.size());
            failures += pending_approx.size();
        end

        $display("%0d ratios transferred, %0d approximations checked", ratios_sent,
                 results_checked);
        $display("%0d limit register writes, idling phases 14/83/0 percent", limit_writes);
        if (failures == 0)
            $display("best_rational_approximation_core_tb passed");
        else
            $display("best_rational_approximation_core_tb failed");
        $finish;
    end

endmodule
